// ----- rtl/core/rational_arithmetic_reducer_top_macros.svh -----
// ----------------------------------------------------------------------------
// rational arithmetic reducer assertion macros
// shared implication checks for the port checker
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_REDUCER_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_REDUCER_TOP_MACROS_SVH

// same-cycle implication
`define RAR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rar check failed in same cycle");

// next-cycle implication
`define RAR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rar check failed in next cycle");

`endif

// ----- rtl/core/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// shared constants, opcodes and types of the rational arithmetic reducer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rar_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int NUM_OUT_BITS = 34;
   localparam int DEN_OUT_BITS = 31;
   localparam int KIND_BITS    = 4;

   localparam logic [KIND_BITS-1:0] KIND_ADD    = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_SUB    = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_MUL    = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_DIV    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_LT     = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_LE     = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_GT     = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_GE     = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_EQ     = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_NE     = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_REDUCE = 4'd10;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/core/rar_if.sv -----
// ----------------------------------------------------------------------------
// rar channel interfaces
// valid/ready channels for operand items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rar_req_if #(
   parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS
);
   logic                                 valid;
   logic                                 ready;
   logic [rar_pkg::KIND_BITS-1:0]        kind;
   logic signed [OPERAND_BITS-1:0]       a_num;
   logic [OPERAND_BITS-2:0]              a_den;
   logic signed [OPERAND_BITS-1:0]       b_num;
   logic [OPERAND_BITS-2:0]              b_den;

   modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rar_pkg::NUM_OUT_BITS-1:0] res_num;
   logic [rar_pkg::DEN_OUT_BITS-1:0]     res_den;
   logic                                 cmp_true;
   logic                                 zero_div_error;

   modport source (output valid, res_num, res_den, cmp_true, zero_div_error, input ready);
   modport sink   (input valid, res_num, res_den, cmp_true, zero_div_error, output ready);
endinterface

// ----- rtl/core/rational_arithmetic_reducer_top.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_reducer_top
// rational alu: sums, products, compare, euclidean gcd and reduction on one divider
// ----------------------------------------------------------------------------
// channel | dir | payload
// req_ch  | in  | kind, a_num, a_den, b_num, b_den
// rsp_ch  | out | res_num, res_den, cmp_true, zero_div_error
//
// one item at a time; req_ch.ready is high only while idle
// products and compares come first; each euclid remainder step and the
//   final quotients run on the shared divider, W = 2*OPERAND_BITS
//   bits wide
// reset (synchronous) returns the sequencer to idle; no clearing pass
// a result waits in the output register until rsp_ch.ready takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_reducer_top #(
   parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS
) (
   input  logic      clock,
   input  logic      reset,
   rar_req_if.sink   req_ch,
   rar_rsp_if.source rsp_ch
);

   localparam int P  = OPERAND_BITS;
   localparam int W  = 2 * P;
   localparam int NB = rar_pkg::NUM_OUT_BITS;
   localparam int DB = rar_pkg::DEN_OUT_BITS;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_FORM  = 8'b0000_0100,
      S_GCD   = 8'b0000_1000,
      S_GWAIT = 8'b0001_0000,
      S_QN    = 8'b0010_0000,
      S_QD    = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [1:0]                    step_ff, step_in;
   logic [rar_pkg::KIND_BITS-1:0] kind_ff, kind_in;
   logic signed [P-1:0]           an_ff, an_in, bn_ff, bn_in;
   logic [P-2:0]                  ad_ff, ad_in, bd_ff, bd_in;
   logic signed [W-1:0]           p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic                          nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [W-1:0]                  magn_ff, magn_in, magd_ff, magd_in;
   logic [W-1:0]                  x_ff, x_in, y_ff, y_in, qn_ff, qn_in;
   logic [W-1:0]                  dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic                          start_ff, start_in;
   logic signed [NB-1:0]          num_ff, num_in;
   logic [DB-1:0]                 den_ff, den_in;
   logic                          cmp_ff, cmp_in, err_ff, err_in;

   logic signed [P:0]             op_a, op_b;
   logic signed [2*P+1:0]         prod;
   logic signed [W-1:0]           an_w, bn_w, ad_w, bd_w, rn, rd, fin_num;
   logic                          is_arith, cmp_val, accept;
   logic [W-1:0]                  quotient, remainder;
   rar_pkg::div_stat_type         div_stat;

   rar_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (dvd_ff),
      .divisor   (dvs_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .stat      (div_stat)
   );

   assign accept = req_ch.valid && req_ch.ready;

   // shared multiplier, one product per step
   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = (P+1)'(an_ff);
            op_b = (kind_ff == rar_pkg::KIND_MUL) ? (P+1)'(bn_ff) : signed'({2'b00, bd_ff});
         end
         2'd1: begin
            op_a = signed'({2'b00, ad_ff});
            op_b = (P+1)'(bn_ff);
         end
         default: begin
            op_a = signed'({2'b00, ad_ff});
            op_b = signed'({2'b00, bd_ff});
         end
      endcase
      prod = op_a * op_b;
   end

   always_comb begin
      an_w = W'(an_ff);
      bn_w = W'(bn_ff);
      ad_w = signed'(W'(ad_ff));
      bd_w = signed'(W'(bd_ff));
      is_arith = 1'b1;
      rn = '0;
      rd = W'(1);
      case (kind_ff)
         rar_pkg::KIND_ADD: begin
            if (ad_ff == bd_ff) begin
               rn = an_w + bn_w;
               rd = ad_w;
            end else begin
               rn = p0_ff + p1_ff;
               rd = p2_ff;
            end
         end
         rar_pkg::KIND_SUB: begin
            if (ad_ff == bd_ff) begin
               rn = an_w - bn_w;
               rd = ad_w;
            end else begin
               rn = p0_ff - p1_ff;
               rd = p2_ff;
            end
         end
         rar_pkg::KIND_MUL: begin
            rn = p0_ff;
            rd = p2_ff;
         end
         rar_pkg::KIND_DIV: begin
            rn = p0_ff;
            rd = p1_ff;
         end
         rar_pkg::KIND_REDUCE: begin
            rn = an_w;
            rd = ad_w;
         end
         default: is_arith = 1'b0;
      endcase
      case (kind_ff)
         rar_pkg::KIND_LT: cmp_val = p0_ff <  p1_ff;
         rar_pkg::KIND_LE: cmp_val = p0_ff <= p1_ff;
         rar_pkg::KIND_GT: cmp_val = p0_ff >  p1_ff;
         rar_pkg::KIND_GE: cmp_val = p0_ff >= p1_ff;
         rar_pkg::KIND_EQ: cmp_val = p0_ff == p1_ff;
         rar_pkg::KIND_NE: cmp_val = p0_ff != p1_ff;
         default:          cmp_val = 1'b0;
      endcase
      // sign of the reduced fraction follows numerator sign times denominator sign
      fin_num = (nneg_ff ^ dneg_ff) ? -signed'(qn_ff) : signed'(qn_ff);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      kind_in  = kind_ff;
      an_in    = an_ff;
      ad_in    = ad_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      nneg_in  = nneg_ff;
      dneg_in  = dneg_ff;
      magn_in  = magn_ff;
      magd_in  = magd_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      qn_in    = qn_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      start_in = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      cmp_in   = cmp_ff;
      err_in   = err_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_ch.kind;
               an_in    = req_ch.a_num;
               ad_in    = req_ch.a_den;
               bn_in    = req_ch.b_num;
               bd_in    = req_ch.b_den;
               step_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            case (step_ff)
               2'd0:    p0_in = W'(prod);
               2'd1:    p1_in = W'(prod);
               default: p2_in = W'(prod);
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            cmp_in = 1'b0;
            err_in = 1'b0;
            num_in = '0;
            den_in = DB'(1);
            if (!is_arith) begin
               cmp_in   = cmp_val;
               state_in = S_OUT;
            end else if (rd == '0) begin
               // zero over zero flags an error; nonzero over zero gives 1/0
               if (rn == '0) begin
                  err_in = 1'b1;
               end else begin
                  num_in = NB'(1);
                  den_in = '0;
               end
               state_in = S_OUT;
            end else begin
               nneg_in  = rn[W-1];
               dneg_in  = rd[W-1];
               magn_in  = rn[W-1] ? W'(-rn) : W'(rn);
               magd_in  = rd[W-1] ? W'(-rd) : W'(rd);
               x_in     = rn[W-1] ? W'(-rn) : W'(rn);
               y_in     = rd[W-1] ? W'(-rd) : W'(rd);
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            start_in = 1'b1;
            if (y_ff == '0) begin
               // x holds the gcd
               dvd_in   = magn_ff;
               dvs_in   = x_ff;
               state_in = S_QN;
            end else begin
               dvd_in   = x_ff;
               dvs_in   = y_ff;
               state_in = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (div_stat.done) begin
               x_in     = y_ff;
               y_in     = remainder;
               state_in = S_GCD;
            end
         end
         S_QN: begin
            if (div_stat.done) begin
               qn_in    = quotient;
               dvd_in   = magd_ff;
               dvs_in   = x_ff;
               start_in = 1'b1;
               state_in = S_QD;
            end
         end
         S_QD: begin
            if (div_stat.done) begin
               num_in   = NB'(fin_num);
               den_in   = DB'(quotient);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 2'd0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         start_ff <= start_in;
      end
      kind_ff <= kind_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      magn_ff <= magn_in;
      magd_ff <= magd_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      qn_ff   <= qn_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      cmp_ff  <= cmp_in;
      err_ff  <= err_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = (state_ff == S_OUT);
   assign rsp_ch.res_num        = num_ff;
   assign rsp_ch.res_den        = den_ff;
   assign rsp_ch.cmp_true       = cmp_ff;
   assign rsp_ch.zero_div_error = err_ff;

endmodule

// ----- rtl/core/rar_div.sv -----
// ----------------------------------------------------------------------------
// rar_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rar_div #(
   parameter int W = 2 * rar_pkg::OPERAND_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [W-1:0]          dividend,
   input  logic [W-1:0]          divisor,
   output logic [W-1:0]          quotient,
   output logic [W-1:0]          remainder,
   output rar_pkg::div_stat_type stat
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // no borrow: the trial subtraction fits
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/core/rar_checker.sv -----
// ----------------------------------------------------------------------------
// rar_checker
// port-level checks of the rational arithmetic reducer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_reducer_top_macros.svh"

module rar_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rar_pkg::NUM_OUT_BITS-1:0] res_num,
   input logic [rar_pkg::DEN_OUT_BITS-1:0] res_den,
   input logic                             cmp_true,
   input logic                             zero_div_error
);

   // a pending result blocks new operands
   `RAR_ASSERT_SAME(a_busy_while_rsp, clock, reset, rsp_valid, !req_ready)
   // a transfer in makes the block busy at once
   `RAR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // stalled result stays offered
   `RAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // error and compare results carry 0/1
   `RAR_ASSERT_SAME(a_flag_zero_one, clock, reset, rsp_valid && (cmp_true || zero_div_error),
      res_num == '0 && res_den == rar_pkg::DEN_OUT_BITS'(1))

endmodule

bind rational_arithmetic_reducer_top rar_checker u_rar_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .res_num        (rsp_ch.res_num),
   .res_den        (rsp_ch.res_den),
   .cmp_true       (rsp_ch.cmp_true),
   .zero_div_error (rsp_ch.zero_div_error)
);

// ----- bench/rational_arithmetic_reducer_top_test.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_reducer_top_test
// drives fraction pairs and opcodes into the rational alu, predicts or takes from
// its table each reduced fraction or compare flag, and checks every result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_reducer_top_test;

   localparam int OB = rar_pkg::OPERAND_BITS;
   localparam int KB = rar_pkg::KIND_BITS;
   localparam int NB = rar_pkg::NUM_OUT_BITS;
   localparam int DB = rar_pkg::DEN_OUT_BITS;

   localparam logic [KB-1:0] KIND_SPARE_LO = 4'd11;
   localparam logic [KB-1:0] KIND_SPARE_HI = 4'd15;
   localparam int  RANDOM_ITEMS = 1430;
   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam int  TAIL_CYCLES = 300;

   typedef struct {
      logic [KB-1:0]        kind;
      logic signed [OB-1:0] a_num;
      logic [OB-2:0]        a_den;
      logic signed [OB-1:0] b_num;
      logic [OB-2:0]        b_den;
   } operands_type;

   typedef struct {
      logic [NB-1:0] res_num;
      logic [DB-1:0] res_den;
      logic          cmp_true;
      logic          zero_div_error;
   } fraction_type;

   typedef struct {
      operands_type ops;
      bit           typed;
      fraction_type want;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rar_req_if req_ch ();
   rar_rsp_if rsp_ch ();

   rational_arithmetic_reducer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fraction_type pending_fracs[$];
   int           fail_count = 0;
   int           result_count = 0;
   int           kind_count[2**KB];
   int           zero_div_seen = 0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   longint       cycle_count = 0;

   // ---------------------------------------------------------------- predictor
   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit lowest_terms(inout longint n, inout longint d);
      longint x, y, r;
      if (d == 0) begin
         if (n == 0) begin
            d = 1;
            return 1'b1;
         end
         n = 1;
         return 1'b0;
      end
      x = magnitude(n);
      y = magnitude(d);
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      n = n / x;
      d = d / x;
      if (d < 0) begin
         d = -d;
         n = -n;
      end
      return 1'b0;
   endfunction

   function automatic fraction_type rational_result(operands_type op);
      fraction_type f;
      longint an, ad, bn, bd, lhs, rhs, n, d;
      bit     err, cmp;
      an = longint'(op.a_num);
      ad = longint'(op.a_den);
      bn = longint'(op.b_num);
      bd = longint'(op.b_den);
      lhs = an * bd;
      rhs = ad * bn;
      n = 0;
      d = 1;
      err = 1'b0;
      cmp = 1'b0;
      case (op.kind)
         rar_pkg::KIND_ADD, rar_pkg::KIND_SUB: begin
            if (ad == bd) begin
               n = (op.kind == rar_pkg::KIND_ADD) ? an + bn : an - bn;
               d = ad;
            end else begin
               n = (op.kind == rar_pkg::KIND_ADD) ? lhs + rhs : lhs - rhs;
               d = ad * bd;
            end
            err = lowest_terms(n, d);
         end
         rar_pkg::KIND_MUL: begin
            n = an * bn;
            d = ad * bd;
            err = lowest_terms(n, d);
         end
         rar_pkg::KIND_DIV: begin
            n = lhs;
            d = rhs;
            err = lowest_terms(n, d);
         end
         rar_pkg::KIND_LT: cmp = lhs < rhs;
         rar_pkg::KIND_LE: cmp = lhs <= rhs;
         rar_pkg::KIND_GT: cmp = lhs > rhs;
         rar_pkg::KIND_GE: cmp = lhs >= rhs;
         rar_pkg::KIND_EQ: cmp = lhs == rhs;
         rar_pkg::KIND_NE: cmp = lhs != rhs;
         rar_pkg::KIND_REDUCE: begin
            n = an;
            d = ad;
            err = lowest_terms(n, d);
         end
         default: ;
      endcase
      f.res_num = n[NB-1:0];
      f.res_den = d[DB-1:0];
      f.cmp_true = cmp;
      f.zero_div_error = err;
      return f;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic vector_type row(logic [KB-1:0] k, int an, int ad, int bn, int bd,
                                      bit typed = 1'b0, longint wn = 0, longint wd = 1,
                                      bit wc = 1'b0, bit we = 1'b0);
      vector_type v;
      v.ops.kind = k;
      v.ops.a_num = OB'(an);
      v.ops.a_den = (OB-1)'(ad);
      v.ops.b_num = OB'(bn);
      v.ops.b_den = (OB-1)'(bd);
      v.typed = typed;
      v.want.res_num = wn[NB-1:0];
      v.want.res_den = wd[DB-1:0];
      v.want.cmp_true = wc;
      v.want.zero_div_error = we;
      return v;
   endfunction

   function automatic logic [OB-1:0] pick_num();
      case ($urandom_range(9))
         0: return {1'b1, {(OB-1){1'b0}}};
         1: return {1'b0, {(OB-1){1'b1}}};
         2: return '0;
         3: return OB'($urandom_range(40) - 20);
         4, 5: return OB'($urandom_range(400) - 200);
         default: return OB'($urandom);
      endcase
   endfunction

   function automatic logic [OB-2:0] pick_den();
      case ($urandom_range(49))
         0: return '0;
         1, 2: return (OB-1)'(1);
         3, 4: return '1;
         default: begin
            if ($urandom_range(2) == 0) return (OB-1)'($urandom);
            return (OB-1)'($urandom_range(60, 1));
         end
      endcase
   endfunction

   function automatic operands_type random_ops();
      operands_type op;
      if ($urandom_range(19) == 0) begin
         op.kind = KB'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      end else begin
         op.kind = KB'($urandom_range(rar_pkg::KIND_REDUCE));
      end
      op.a_num = pick_num();
      op.a_den = pick_den();
      op.b_num = pick_num();
      // shared denominators take the short add/sub path
      op.b_den = ($urandom_range(3) == 0) ? op.a_den : pick_den();
      return op;
   endfunction

   task automatic send(vector_type v);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= v.ops.kind;
      req_ch.a_num <= v.ops.a_num;
      req_ch.a_den <= v.ops.a_den;
      req_ch.b_num <= v.ops.b_num;
      req_ch.b_den <= v.ops.b_den;
      do @(posedge clock); while (!req_ch.ready);
      if (v.typed) begin
         pending_fracs.push_back(v.want);
      end else begin
         pending_fracs.push_back(rational_result(v.ops));
      end
      kind_count[v.ops.kind]++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_fracs.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- checking
   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      fraction_type w;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (pending_fracs.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            w = pending_fracs.pop_front();
            if (rsp_ch.zero_div_error) zero_div_seen++;
            if (rsp_ch.res_num !== w.res_num) begin
               $error("res_num expected %0h actual %0h", w.res_num, rsp_ch.res_num);
               fail_count++;
            end
            if (rsp_ch.res_den !== w.res_den) begin
               $error("res_den expected %0h actual %0h", w.res_den, rsp_ch.res_den);
               fail_count++;
            end
            if (rsp_ch.cmp_true !== w.cmp_true) begin
               $error("cmp_true expected %0b actual %0b", w.cmp_true, rsp_ch.cmp_true);
               fail_count++;
            end
            if (rsp_ch.zero_div_error !== w.zero_div_error) begin
               $error("zero_div_error expected %0b actual %0b",
                      w.zero_div_error, rsp_ch.zero_div_error);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      vector_type tbl[$];
      int         phase;
      int         spare_total;
      int         cmp_total;
      req_ch.valid = 1'b0;
      req_ch.kind  = rar_pkg::KIND_ADD;
      req_ch.a_num = '0;
      req_ch.a_den = '0;
      req_ch.b_num = '0;
      req_ch.b_den = '0;
      rsp_ch.ready = 1'b0;
      spare_total  = 0;
      cmp_total    = 0;
      foreach (kind_count[i]) kind_count[i] = 0;

      tbl.push_back(row(rar_pkg::KIND_ADD, 1, 2, 1, 3));
      tbl.push_back(row(rar_pkg::KIND_ADD, 1, 4, 1, 4, 1'b1, 1, 2));
      tbl.push_back(row(rar_pkg::KIND_SUB, 3, 7, 3, 7, 1'b1, 0, 1));
      tbl.push_back(row(rar_pkg::KIND_SUB, -32768, 1, 32767, 32767));
      tbl.push_back(row(rar_pkg::KIND_MUL, -32768, 1, -32768, 1, 1'b1, 1073741824, 1));
      tbl.push_back(row(rar_pkg::KIND_MUL, 32767, 32767, -32768, 32767));
      tbl.push_back(row(rar_pkg::KIND_DIV, 5, 3, 0, 9, 1'b1, 1, 0));
      tbl.push_back(row(rar_pkg::KIND_DIV, 0, 3, 0, 9, 1'b1, 0, 1, 1'b0, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_DIV, -7, 2, 3, 4));
      tbl.push_back(row(rar_pkg::KIND_LT, 1, 3, 1, 2, 1'b1, 0, 1, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_LE, 2, 4, 1, 2, 1'b1, 0, 1, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_GT, -32768, 1, 32767, 1, 1'b1, 0, 1, 1'b0));
      tbl.push_back(row(rar_pkg::KIND_GE, 32767, 1, -32768, 32767, 1'b1, 0, 1, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_EQ, 2, 4, 3, 6, 1'b1, 0, 1, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_NE, 2, 4, 3, 6, 1'b1, 0, 1, 1'b0));
      tbl.push_back(row(rar_pkg::KIND_EQ, 5, 0, 0, 7, 1'b1, 0, 1, 1'b0));
      tbl.push_back(row(rar_pkg::KIND_REDUCE, 6, 4, 0, 1, 1'b1, 3, 2));
      tbl.push_back(row(rar_pkg::KIND_REDUCE, 0, 0, 9, 9, 1'b1, 0, 1, 1'b0, 1'b1));
      tbl.push_back(row(rar_pkg::KIND_REDUCE, -32768, 32767, 0, 1));
      tbl.push_back(row(rar_pkg::KIND_REDUCE, 0, 5, 0, 1, 1'b1, 0, 1));
      // zero denominator on one side only: nonzero over zero, then zero over zero
      tbl.push_back(row(rar_pkg::KIND_ADD, 3, 0, 4, 5, 1'b1, 1, 0));
      tbl.push_back(row(rar_pkg::KIND_MUL, 0, 0, 4, 5, 1'b1, 0, 1, 1'b0, 1'b1));
      tbl.push_back(row(KIND_SPARE_LO, 123, 45, -6, 7, 1'b1, 0, 1));
      tbl.push_back(row(KIND_SPARE_HI, -1, 32767, -1, 32767, 1'b1, 0, 1));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (tbl[i]) send(tbl[i]);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         gap_pct   = (phase == 0) ? 25 : (phase == 1) ? 79 : 0;
         stall_pct = (phase == 0) ? 79 : (phase == 1) ? 25 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            vector_type v;
            v.ops = random_ops();
            v.typed = 1'b0;
            send(v);
            // hold off once per phase until the pipe is empty
            if (n == RANDOM_ITEMS / 6) drain();
         end
      end
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) spare_total += kind_count[k];
      for (int k = rar_pkg::KIND_LT; k <= rar_pkg::KIND_NE; k++) cmp_total += kind_count[k];
      $display("covered %0d results: add %0d sub %0d mul %0d div %0d reduce %0d spare %0d",
               result_count, kind_count[rar_pkg::KIND_ADD], kind_count[rar_pkg::KIND_SUB],
               kind_count[rar_pkg::KIND_MUL], kind_count[rar_pkg::KIND_DIV],
               kind_count[rar_pkg::KIND_REDUCE], spare_total);
      $display("compares %0d, zero over zero errors %0d, three idling phases",
               cmp_total, zero_div_seen);
      if (fail_count == 0 && pending_fracs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rar_pkg.sv
rtl/core/rar_if.sv
rtl/core/rar_div.sv
rtl/core/rational_arithmetic_reducer_top.sv
rtl/core/rar_checker.sv
bench/rational_arithmetic_reducer_top_test.sv
